@@ rtl/ppw_pkg.sv @@
package ppw_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int FRAC_BITS_DEF  = 10;
  localparam int INV_FRAC       = 30;
  localparam int INV_W          = 48;
  localparam int IMG_W          = 21;
  localparam int REG_W          = 63;
  localparam int NUM_REGS       = 5;
  localparam int ADDR_W         = 6;

  // register indexes
  localparam logic [2:0] REG_VEC_A  = 3'd0;
  localparam logic [2:0] REG_VEC_B  = 3'd1;
  localparam logic [2:0] REG_VEC_C  = 3'd2;
  localparam logic [2:0] REG_ORIGIN = 3'd3;
  localparam logic [2:0] REG_MASK   = 3'd4;

  // inverse cache handed from the solver to the datapath
  typedef struct packed {
    logic                     singular;
    logic                     busy;
    logic signed [INV_W-1:0]  e0;
    logic signed [INV_W-1:0]  e1;
    logic signed [INV_W-1:0]  e2;
    logic signed [INV_W-1:0]  e3;
    logic signed [INV_W-1:0]  e4;
    logic signed [INV_W-1:0]  e5;
    logic signed [INV_W-1:0]  e6;
    logic signed [INV_W-1:0]  e7;
    logic signed [INV_W-1:0]  e8;
  } ppw_inv_t;

endpackage

@@ rtl/ppw_inv_solver.sv @@
// Recomputes the inverse box matrix after reset and every register write.
// Sequencer: cofactor products over a shared multiplier, then a restoring
// divider for each of the nine entries, one quotient bit per cycle, skipped when singular.
module ppw_inv_solver #(
  parameter int COORD_BITS = ppw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ppw_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      kick,
  input  logic [3*COORD_BITS-1:0]   vec_a,
  input  logic [3*COORD_BITS-1:0]   vec_b,
  input  logic [3*COORD_BITS-1:0]   vec_c,
  output ppw_pkg::ppw_inv_t         inv
);
  import ppw_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int PW    = 2*CW;           // product
  localparam int CFW   = 2*CW + 1;       // cofactor
  localparam int DW    = 3*CW + 3;       // determinant
  localparam int SH    = FRAC_BITS + INV_FRAC;
  localparam int NW    = DW + SH + 1;    // dividend width
  localparam int STEPS = CFW + SH;       // quotient bits per entry
  localparam int DCW   = 7;              // divide step counter
  localparam logic [INV_W-1:0] LIMIT = {1'b0, {(INV_W-1){1'b1}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [4:0]                step_r, step_nxt;
  logic [DCW-1:0]            cnt_r, cnt_nxt;
  logic signed [CW-1:0]      v [9];
  logic signed [PW-1:0]      prod_r;
  logic signed [CFW-1:0]     cof_r [9];
  logic signed [DW-1:0]      det_r;
  logic [NW-1:0]             rem_r;
  logic [NW-1:0]             quo_r;
  logic [DW-1:0]             dmag;
  logic                      neg_r;
  logic signed [INV_W-1:0]   ent_r [9];
  logic                      sing_r;
  logic signed [CW-1:0]      ma, mb;
  logic [3:0]                ei;
  logic [3:0]                cj;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k]   = vec_a[k*CW +: CW];
      v[3+k] = vec_b[k*CW +: CW];
      v[6+k] = vec_c[k*CW +: CW];
    end
  end

  // operand select: step 2j and 2j+1 form the two products of cofactor j;
  // every other step selects zero operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_r)
      5'd0:  begin ma = v[4]; mb = v[8]; end
      5'd1:  begin ma = v[7]; mb = v[5]; end
      5'd2:  begin ma = v[7]; mb = v[2]; end
      5'd3:  begin ma = v[1]; mb = v[8]; end
      5'd4:  begin ma = v[1]; mb = v[5]; end
      5'd5:  begin ma = v[4]; mb = v[2]; end
      5'd6:  begin ma = v[6]; mb = v[5]; end
      5'd7:  begin ma = v[3]; mb = v[8]; end
      5'd8:  begin ma = v[0]; mb = v[8]; end
      5'd9:  begin ma = v[6]; mb = v[2]; end
      5'd10: begin ma = v[3]; mb = v[2]; end
      5'd11: begin ma = v[0]; mb = v[5]; end
      5'd12: begin ma = v[3]; mb = v[7]; end
      5'd13: begin ma = v[6]; mb = v[4]; end
      5'd14: begin ma = v[6]; mb = v[1]; end
      5'd15: begin ma = v[0]; mb = v[7]; end
      5'd16: begin ma = v[0]; mb = v[4]; end
      5'd17: begin ma = v[3]; mb = v[1]; end
      default: ;
    endcase
  end

  assign ei   = step_r[3:0];
  // cofactor fed by the product registered in the previous step
  assign cj   = step_r[0] ? step_r[4:1] : step_r[4:1] - 4'd1;
  assign dmag = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: ;
      S_COF: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd18) begin
          state_nxt = S_DET;
          step_nxt  = '0;
        end
      end
      S_DET: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd3) begin
          state_nxt = S_DIVS;
          step_nxt  = '0;
        end
      end
      S_DIVS: begin
        cnt_nxt = '0;
        if (sing_r) state_nxt = S_DONE;
        else        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + DCW'(1);
        if (cnt_r == DCW'(STEPS)) begin
          step_nxt  = step_r + 5'd1;
          state_nxt = (step_r == 5'd8) ? S_DONE : S_DIVS;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (kick) begin
      state_nxt = S_COF;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COF;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // rounded quotient, ties away from zero, saturated
  function automatic logic [INV_W-1:0] rnd_q();
    logic [NW:0] q;
    q = {1'b0, quo_r} + {{NW{1'b0}}, ({rem_r, 1'b0} >= {1'b0, NW'(dmag)})};
    if (q > (NW+1)'(LIMIT)) return LIMIT;
    return INV_W'(q);
  endfunction

  // datapath: one multiply per cycle, registered, then accumulate
  always_ff @(posedge clk) begin
    prod_r <= PW'(ma) * PW'(mb);
    if (state_r == S_COF && step_r != 5'd0) begin
      if (step_r[0])
        cof_r[cj] <= CFW'(prod_r);
      else
        cof_r[cj] <= cof_r[cj] - CFW'(prod_r);
    end
    if (state_r == S_DET) begin
      unique case (step_r)
        5'd0: det_r <= '0;
        5'd1: det_r <= det_r + DW'(cof_r[0] * v[0]);
        5'd2: det_r <= det_r + DW'(cof_r[3] * v[1]);
        5'd3: det_r <= det_r + DW'(cof_r[6] * v[2]);
        default: ;
      endcase
    end
    if (state_r == S_DIVS) begin
      rem_r <= '0;
      // dividend magnitude at the top, zeros below
      quo_r <= NW'(cof_r[ei][CFW-1] ? -cof_r[ei] : cof_r[ei]) << (NW - CFW);
      neg_r <= cof_r[ei][CFW-1] ^ det_r[DW-1];
      if (sing_r) for (int k = 0; k < 9; k++) ent_r[k] <= '0;
    end
    if (state_r == S_DIV) begin
      if (cnt_r < DCW'(STEPS)) begin
        // next dividend bit into the remainder, quotient bit in at the bottom
        if ({rem_r[NW-2:0], quo_r[NW-1]} >= NW'(dmag)) begin
          rem_r <= {rem_r[NW-2:0], quo_r[NW-1]} - NW'(dmag);
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[NW-2:0], quo_r[NW-1]};
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
      end else begin
        ent_r[ei] <= neg_r ? -$signed(rnd_q()) : $signed(rnd_q());
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sing_r <= 1'b0;
    else if (state_r == S_DET && step_r == 5'd3)
      sing_r <= (det_r + DW'(cof_r[6] * v[2])) == '0;
  end

  assign inv.singular = sing_r;
  assign inv.busy     = state_r != S_IDLE;
  assign inv.e0 = ent_r[0];
  assign inv.e1 = ent_r[1];
  assign inv.e2 = ent_r[2];
  assign inv.e3 = ent_r[3];
  assign inv.e4 = ent_r[4];
  assign inv.e5 = ent_r[5];
  assign inv.e6 = ent_r[6];
  assign inv.e7 = ent_r[7];
  assign inv.e8 = ent_r[8];

endmodule

@@ rtl/ppw_wrap_pipe.sv @@
// Five-stage wrap datapath: offset, 9 products, sums and floor,
// image times box vector products, final subtract and clamp.
module ppw_wrap_pipe #(
  parameter int COORD_BITS = ppw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ppw_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [COORD_BITS-1:0] px, py, pz,
  input  logic                     in_last,
  input  logic [3*COORD_BITS-1:0]  vec_a, vec_b, vec_c, org,
  input  logic [2:0]               pmask,
  input  ppw_pkg::ppw_inv_t        inv,
  output logic                     out_vld,
  output logic signed [COORD_BITS-1:0] wx, wy, wz,
  output logic signed [ppw_pkg::IMG_W-1:0] ia, ib, ic,
  output logic                     sing,
  output logic                     last_o
);
  import ppw_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int XW = CW + 1;
  localparam int MW = INV_W + XW;
  localparam int AW = MW + 2;
  localparam int SH = FRAC_BITS + INV_FRAC;
  localparam int QW = AW - SH;
  localparam int GW = CW + IMG_W;
  localparam int WW = GW + 3;

  logic [4:0]               v_r;
  logic signed [CW-1:0]     p1 [3], p2 [3], p3 [3], p4 [3];
  logic signed [XW-1:0]     x1 [3];
  logic                     l_r [4];
  logic signed [MW-1:0]     m2 [9];
  logic signed [IMG_W-1:0]  g3 [3];
  logic signed [IMG_W-1:0]  g3_d [3];
  logic signed [GW-1:0]     q4 [9];
  logic signed [INV_W-1:0]  ie [9];
  logic signed [CW-1:0]     bv [9];
  logic signed [CW-1:0]     pin [3];
  logic signed [AW-1:0]     acc [3];
  logic signed [QW-1:0]     fl [3];
  logic signed [WW-1:0]     wsum [3];
  logic signed [CW-1:0]     wo [3];

  assign ie = '{inv.e0, inv.e1, inv.e2, inv.e3, inv.e4, inv.e5, inv.e6, inv.e7, inv.e8};
  assign pin = '{px, py, pz};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bv[k]   = vec_a[k*CW +: CW];
      bv[3+k] = vec_b[k*CW +: CW];
      bv[6+k] = vec_c[k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[3:0], in_vld};
  end

  // stage 1: subtract origin
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p1[k] <= pin[k];
      x1[k] <= XW'(pin[k]) - XW'($signed(org[k*CW +: CW]));
    end
    l_r[0] <= in_last;
  end

  // stage 2: inverse products, entry 3k+i times x[k]
  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) m2[j] <= MW'(ie[j]) * MW'(x1[j/3]);
    p2 <= p1;
    l_r[1] <= l_r[0];
  end

  // stage 3: sum, floor, saturate; zero when singular or the axis is masked off
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(m2[i]) + AW'(m2[3+i]) + AW'(m2[6+i]);
      fl[i]  = QW'(acc[i] >>> SH);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (inv.singular || !pmask[i])          g3[i] <= '0;
      else if (fl[i] > QW'(2**(IMG_W-1) - 1)) g3[i] <= IMG_W'(2**(IMG_W-1) - 1);
      else if (fl[i] < -QW'(2**(IMG_W-1)))    g3[i] <= IMG_W'(-(2**(IMG_W-1)));
      else                                    g3[i] <= IMG_W'(fl[i]);
    end
    p3 <= p2;
    l_r[2] <= l_r[1];
  end

  // stage 4: image times box vector component, index 3i+k
  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) q4[j] <= GW'(bv[j]) * GW'(g3[j/3]);
    p4 <= p3;
    l_r[3] <= l_r[2];
  end

  // stage 5: subtract and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wsum[k] = WW'(p4[k]) - WW'(q4[k]) - WW'(q4[3+k]) - WW'(q4[6+k]);
      if (wsum[k] > WW'(2**(CW-1) - 1))   wo[k] = CW'(2**(CW-1) - 1);
      else if (wsum[k] < -WW'(2**(CW-1))) wo[k] = CW'(-(2**(CW-1)));
      else                                wo[k] = CW'(wsum[k]);
    end
  end

  always_ff @(posedge clk) begin
    wx <= wo[0];
    wy <= wo[1];
    wz <= wo[2];
    ia <= g3_d[0];
    ib <= g3_d[1];
    ic <= g3_d[2];
    sing <= inv.singular;
    last_o <= l_r[3];
  end

  always_ff @(posedge clk) g3_d <= g3;

  assign out_vld = v_r[4];

endmodule

@@ rtl/periodic_position_wrap_top.sv @@
// Triclinic periodic wrap. One position is taken per cycle while busy is
// low; its result leaves the registered pipeline on out_strobe, for one cycle,
// and cannot be stalled. After reset and after every register write the
// inverse box matrix is recomputed by a shared multiplier and a one bit
// per cycle divider; busy is high during that time and no item is taken.
// box_singular flags a zero determinant, in which case positions pass
// through unwrapped.
module periodic_position_wrap_top #(
  parameter int COORD_BITS = ppw_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ppw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  input  logic                          in_last_particle,
  output logic                          out_strobe,
  output logic signed [COORD_BITS-1:0]  out_wrapped_x,
  output logic signed [COORD_BITS-1:0]  out_wrapped_y,
  output logic signed [COORD_BITS-1:0]  out_wrapped_z,
  output logic signed [ppw_pkg::IMG_W-1:0] out_image_a,
  output logic signed [ppw_pkg::IMG_W-1:0] out_image_b,
  output logic signed [ppw_pkg::IMG_W-1:0] out_image_c,
  output logic                          out_box_singular,
  output logic                          out_last_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppw_pkg::ADDR_W-1:0]    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import ppw_pkg::*;

  localparam int VW = 3*COORD_BITS;

  logic [REG_W-1:0] reg_r [NUM_REGS];
  logic             wr;
  logic [2:0]       widx;
  ppw_inv_t         inv;

  assign pready = 1'b1;
  assign widx   = paddr[5:3];
  assign wr     = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[REG_VEC_A]  <= REG_W'(64'd1 << FRAC_BITS);
      reg_r[REG_VEC_B]  <= REG_W'(64'd1 << (FRAC_BITS + COORD_BITS));
      reg_r[REG_VEC_C]  <= REG_W'(64'd1 << (FRAC_BITS + 2*COORD_BITS));
      reg_r[REG_ORIGIN] <= '0;
      reg_r[REG_MASK]   <= '0;
    end else if (wr) begin
      unique case (widx)
        REG_VEC_A, REG_VEC_B, REG_VEC_C, REG_ORIGIN: reg_r[widx] <= pwdata[REG_W-1:0];
        REG_MASK: reg_r[REG_MASK] <= REG_W'(pwdata[2:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (widx < 3'(NUM_REGS)) prdata = 64'(reg_r[widx]);
  end

  ppw_inv_solver #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_solver (
    .clk(clk), .rst_n(rst_n), .kick(wr && widx < 3'(NUM_REGS)),
    .vec_a(reg_r[REG_VEC_A][VW-1:0]), .vec_b(reg_r[REG_VEC_B][VW-1:0]),
    .vec_c(reg_r[REG_VEC_C][VW-1:0]), .inv(inv)
  );

  assign busy = inv.busy;

  ppw_wrap_pipe #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy),
    .px(in_pos_x), .py(in_pos_y), .pz(in_pos_z), .in_last(in_last_particle),
    .vec_a(reg_r[REG_VEC_A][VW-1:0]), .vec_b(reg_r[REG_VEC_B][VW-1:0]),
    .vec_c(reg_r[REG_VEC_C][VW-1:0]), .org(reg_r[REG_ORIGIN][VW-1:0]),
    .pmask(reg_r[REG_MASK][2:0]), .inv(inv),
    .out_vld(out_strobe), .wx(out_wrapped_x), .wy(out_wrapped_y),
    .wz(out_wrapped_z), .ia(out_image_a), .ib(out_image_b), .ic(out_image_c),
    .sing(out_box_singular), .last_o(out_last_out)
  );

`ifndef SYNTHESIS
  // every result traces back to an item taken at the pipeline input
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 5)) else $error("orphan result");
  // singular results carry no images
  a_sing_img: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_box_singular) |->
      (out_image_a == '0 && out_image_b == '0 && out_image_c == '0))
    else $error("image on singular box");
  // a write to the mask register restarts the solver
  a_kick: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[5:3] == REG_MASK) |=> busy)
    else $error("solver not restarted");
`endif

endmodule

@@ verif/periodic_position_wrap_checker.sv @@
`timescale 1ns / 100ps

// Watches the position and result channels and the register port, predicts each
// wrapped position and compares it with what the block returns.
module periodic_position_wrap_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic signed [20:0]  in_pos_x,
  input  logic signed [20:0]  in_pos_y,
  input  logic signed [20:0]  in_pos_z,
  input  logic                in_last_particle,
  input  logic                out_strobe,
  input  logic signed [20:0]  out_wrapped_x,
  input  logic signed [20:0]  out_wrapped_y,
  input  logic signed [20:0]  out_wrapped_z,
  input  logic signed [20:0]  out_image_a,
  input  logic signed [20:0]  out_image_b,
  input  logic signed [20:0]  out_image_c,
  input  logic                out_box_singular,
  input  logic                out_last_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ppw_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  wraps_pending,
  output int                  wraps_checked
);
  import ppw_pkg::*;

  localparam int SHIFT = 10 + INV_FRAC;
  localparam logic [127:0] INV_SAT = (128'd1 << 47) - 1;

  typedef struct packed {
    logic signed [20:0] wx;
    logic signed [20:0] wy;
    logic signed [20:0] wz;
    logic signed [20:0] img_a;
    logic signed [20:0] img_b;
    logic signed [20:0] img_c;
    logic               singular;
    logic               last;
  } wrap_result_t;

  logic [62:0]             box_regs[NUM_REGS];
  logic signed [INV_W-1:0] inv_box[9];
  logic                    box_is_singular;
  wrap_result_t            wrap_queue[$];

  // signed 21-bit component k of a packed vector register
  function automatic longint vec_comp(input logic [62:0] r, input int k);
    logic signed [20:0] c;
    c = r[k*21 +: 21];
    return c;
  endfunction

  function automatic longint clamp21(input logic signed [127:0] v);
    if (v > 1048575) return 1048575;
    if (v < -1048576) return -1048576;
    return longint'(v);
  endfunction

  // cofactor * 2^40 / det, rounded half away from zero, magnitude saturated
  function automatic logic signed [INV_W-1:0] inv_div(input longint cof, input longint det);
    logic [127:0] num, den, quo, rem;
    logic signed [INV_W-1:0] res;
    num = (cof < 0) ? -cof : cof;
    num = num << SHIFT;
    den = (det < 0) ? -det : det;
    quo = num / den;
    rem = num % den;
    if (quo <= INV_SAT && 2 * rem >= den) quo = quo + 1;
    if (quo > INV_SAT) quo = INV_SAT;
    res = quo[INV_W-1:0];
    return ((cof < 0) != (det < 0)) ? -res : res;
  endfunction

  // rebuild the cached inverse from the box vectors
  function automatic void refresh_inverse();
    longint va[3], vb[3], vc[3], cof[9], det;
    for (int k = 0; k < 3; k++) begin
      va[k] = vec_comp(box_regs[REG_VEC_A], k);
      vb[k] = vec_comp(box_regs[REG_VEC_B], k);
      vc[k] = vec_comp(box_regs[REG_VEC_C], k);
    end
    cof[0] = vb[1] * vc[2] - vc[1] * vb[2];
    cof[1] = vc[1] * va[2] - va[1] * vc[2];
    cof[2] = va[1] * vb[2] - vb[1] * va[2];
    cof[3] = vc[0] * vb[2] - vb[0] * vc[2];
    cof[4] = va[0] * vc[2] - vc[0] * va[2];
    cof[5] = vb[0] * va[2] - va[0] * vb[2];
    cof[6] = vb[0] * vc[1] - vc[0] * vb[1];
    cof[7] = vc[0] * va[1] - va[0] * vc[1];
    cof[8] = va[0] * vb[1] - vb[0] * va[1];
    det = va[0] * cof[0] + va[1] * cof[3] + va[2] * cof[6];
    box_is_singular = (det == 0);
    for (int k = 0; k < 9; k++) inv_box[k] = box_is_singular ? '0 : inv_div(cof[k], det);
  endfunction

  function automatic wrap_result_t wrap_position(input logic signed [20:0] px,
      input logic signed [20:0] py, input logic signed [20:0] pz, input logic last);
    longint pos[3], rel[3], img[3], w;
    logic signed [127:0] acc;
    wrap_result_t res;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    for (int k = 0; k < 3; k++) begin
      rel[k] = pos[k] - vec_comp(box_regs[REG_ORIGIN], k);
      img[k] = 0;
    end
    // image counts from floor of the fractional coordinates
    if (!box_is_singular) begin
      for (int i = 0; i < 3; i++) begin
        if (box_regs[REG_MASK][i]) begin
          acc = '0;
          for (int k = 0; k < 3; k++) acc = acc + inv_box[3*k+i] * rel[k];
          img[i] = clamp21(acc >>> SHIFT);
        end
      end
    end
    // subtract the images from the original position
    for (int k = 0; k < 3; k++) begin
      w = pos[k];
      for (int i = 0; i < 3; i++) w = w - vec_comp(box_regs[i], k) * img[i];
      pos[k] = clamp21(w);
    end
    res.wx = 21'(pos[0]); res.wy = 21'(pos[1]); res.wz = 21'(pos[2]);
    res.img_a = 21'(img[0]); res.img_b = 21'(img[1]); res.img_c = 21'(img[2]);
    res.singular = box_is_singular;
    res.last = last;
    return res;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    wraps_checked = 0;
    wraps_pending = 0;
  end

  always @(posedge clk) begin
    wrap_result_t exp_r;
    int idx;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) box_regs[k] = 63'(64'd1024 << (k * 21));
      box_regs[REG_ORIGIN] = '0;
      box_regs[REG_MASK] = '0;
      refresh_inverse();
      wrap_queue.delete();
    end else begin
      // results first, then new items
      if (out_strobe) begin
        if (wrap_queue.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item outstanding, got x=%0d", $time, out_wrapped_x);
        end else begin
          exp_r = wrap_queue.pop_front();
          wraps_checked++;
          check_field("wrapped_x", exp_r.wx, out_wrapped_x);
          check_field("wrapped_y", exp_r.wy, out_wrapped_y);
          check_field("wrapped_z", exp_r.wz, out_wrapped_z);
          check_field("image_a", exp_r.img_a, out_image_a);
          check_field("image_b", exp_r.img_b, out_image_b);
          check_field("image_c", exp_r.img_c, out_image_c);
          check_field("box_singular", exp_r.singular, out_box_singular);
          check_field("last_out", exp_r.last, out_last_out);
        end
      end
      if (start && !busy)
        wrap_queue.push_back(wrap_position(in_pos_x, in_pos_y, in_pos_z, in_last_particle));
      if (psel && penable && pwrite && pready) begin
        idx = paddr >> 3;
        if (idx < NUM_REGS) begin
          box_regs[idx] = (idx == REG_MASK) ? 63'(pwdata[2:0]) : pwdata[62:0];
          refresh_inverse();
        end
      end
    end
    wraps_pending = wrap_queue.size();
  end

endmodule

@@ verif/periodic_position_wrap_top_test.sv @@
`timescale 1ns / 100ps

module periodic_position_wrap_top_test;
  import ppw_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic clk, rst_n, start, busy;
  logic signed [20:0] in_pos_x, in_pos_y, in_pos_z;
  logic in_last_particle;
  logic out_strobe, out_box_singular, out_last_out;
  logic signed [20:0] out_wrapped_x, out_wrapped_y, out_wrapped_z;
  logic signed [20:0] out_image_a, out_image_b, out_image_c;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;

  int fail_count, wraps_pending, wraps_checked;
  int items_sent, burst_left, idle_cycles, cfg_writes;
  bit gaps_on;

  periodic_position_wrap_top DUT (.*);

  periodic_position_wrap_checker wrap_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[periodic_position_wrap_top] ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic logic [62:0] pack_vec(input longint x, input longint y, input longint z);
    logic [20:0] cx, cy, cz;
    cx = 21'(x); cy = 21'(y); cz = 21'(z);
    return {cz, cy, cx};
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic longint rand_signed(input int mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic reg_write(input logic [2:0] idx, input logic [62:0] value);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= {1'b0, value};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cfg_writes++;
  endtask

  // let everything in flight drain before touching the registers
  task automatic drain();
    while (wraps_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pos(input longint x, input longint y, input longint z, input logic last);
    if (burst_left == 0) begin
      if (gaps_on) begin
        start <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1;
    in_pos_x <= 21'(x); in_pos_y <= 21'(y); in_pos_z <= 21'(z);
    in_last_particle <= last;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic stop_items();
    start <= 0;
    burst_left = 0;
  endtask

  // a reasonable triclinic box: dominant diagonal, modest skew
  task automatic load_triclinic_box();
    int d0, d1, d2;
    d0 = $urandom_range(256, 60000);
    d1 = $urandom_range(256, 60000);
    d2 = $urandom_range(256, 60000);
    reg_write(REG_VEC_A, pack_vec(d0, 0, 0));
    reg_write(REG_VEC_B, pack_vec(rand_signed(d1 / 2), d1, 0));
    reg_write(REG_VEC_C, pack_vec(rand_signed(d2 / 2), rand_signed(d2 / 2), d2));
    reg_write(REG_ORIGIN, pack_vec(rand_signed(100000), rand_signed(100000),
                                   rand_signed(100000)));
  endtask

  task automatic random_positions(input int count, input int mag);
    longint lim;
    for (int n = 0; n < count; n++) begin
      lim = ($urandom_range(0, 3) == 0) ? 1048575 : mag;
      send_pos(rand_signed(lim), rand_signed(lim), rand_signed(lim),
               1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [62:0] va;
    start = 0; in_pos_x = 0; in_pos_y = 0; in_pos_z = 0; in_last_particle = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    items_sent = 0; burst_left = 0; idle_cycles = 0; cfg_writes = 0; gaps_on = 1;
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // unit box, nothing periodic
    send_pos(1048575, -1048576, 0, 1);
    send_pos(-1048576, 1048575, -1, 0);
    send_pos(1024, -1024, 512, 1);
    send_pos(0, 0, 0, 0);
    stop_items();
    drain();

    // unit box, all axes wrap: extremes saturate nothing but give large images
    reg_write(REG_MASK, 63'd7);
    send_pos(1048575, 1048575, 1048575, 0);
    send_pos(-1048576, -1048576, -1048576, 1);
    send_pos(1023, 1024, -1, 0);
    send_pos(-1024, -1025, 1, 1);
    send_pos(0, 512, -512, 0);
    random_positions(30, 1048575);
    stop_items();
    drain();

    // index past the register list must be ignored
    reg_write(3'd5, '1);
    send_pos(3000, -3000, 5000, 1);
    stop_items();
    drain();

    // one LSB box: each image equals its position and every position wraps to zero
    reg_write(REG_VEC_A, pack_vec(1, 0, 0));
    reg_write(REG_VEC_B, pack_vec(0, 1, 0));
    reg_write(REG_VEC_C, pack_vec(0, 0, 1));
    send_pos(1048575, -1048576, 5, 0);
    send_pos(-1048576, 1048575, -5, 1);
    stop_items();
    drain();

    for (int p = 2; p < 13; p++) begin
      gaps_on = (p % 3 != 0);
      case (p % 5)
        0, 4: load_triclinic_box();
        1: begin
          // arbitrary register contents
          for (int r = 0; r < 4; r++) reg_write(3'(r), rand63());
        end
        2: begin
          // coplanar vectors: zero determinant
          va = rand63();
          reg_write(REG_VEC_A, va);
          reg_write(REG_VEC_B, $urandom_range(0, 1) ? va : 63'(0));
          reg_write(REG_VEC_C, rand63());
        end
        default: begin
          // box vectors at the component extremes
          reg_write(REG_VEC_A, pack_vec(1048575, -1048576, 0));
          reg_write(REG_VEC_B, pack_vec(-1048576, 0, 1048575));
          reg_write(REG_VEC_C, pack_vec(0, 1048575, -1048576));
          reg_write(REG_ORIGIN, pack_vec(-1048576, 1048575, -1048576));
        end
      endcase
      reg_write(REG_MASK, 63'((p == 2) ? 7 : (p == 3) ? 0 : $urandom_range(0, 7)));
      random_positions(45, 200000);
      stop_items();
      drain();
    end

    while (wraps_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d positions over %0d register writes, %0d results compared.",
             items_sent, cfg_writes, wraps_checked);
    $display("Boxes covered: unit, one LSB, triclinic, arbitrary, singular, extreme.");
    if (fail_count == 0) $display("[periodic_position_wrap_top] OK");
    else $display("[periodic_position_wrap_top] ERROR");
    $finish;
  end

endmodule
